### rtl/mtbv_pkg.sv
// Shared types and constants of the movement token bucket validator.
`default_nettype none
package mtbv_pkg;

  localparam int ACTOR_SLOTS_DEF = 64;
  localparam int MAX_JUMP_DEF    = 4096;

  localparam int SLOT_W     = 6;
  localparam int POS_W      = 24;
  localparam int CELL_W     = 32;
  localparam int TIME_W     = 32;
  localparam int RATE_W     = 16;
  localparam int BKT_W      = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int VERDICT_W  = 3;

  localparam int MS_PER_S    = 1000;
  localparam int MILLI       = 1000;
  localparam int SQ_SCALE    = 1000000;
  localparam int SQ_SCALE_W  = 20;

  localparam logic [RATE_W-1:0] H_RATE_RST    = 16'd1000;
  localparam logic [RATE_W-1:0] UP_RATE_RST   = 16'd1000;
  localparam logic [RATE_W-1:0] DN_RATE_RST   = 16'd2000;
  localparam logic [RATE_W-1:0] BURST_RST     = 16'd2000;
  localparam logic [RATE_W-1:0] GRACE_RST     = 16'd1000;
  localparam logic [RATE_W-1:0] SNAP_INT_RST  = 16'd500;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_CHECK_EN = 3'd0,
    CFG_ENFORCE  = 3'd1,
    CFG_H_RATE   = 3'd2,
    CFG_UP_RATE  = 3'd3,
    CFG_DN_RATE  = 3'd4,
    CFG_BURST    = 3'd5,
    CFG_GRACE    = 3'd6,
    CFG_SNAP_INT = 3'd7
  } cfg_idx_t;

  typedef enum logic [VERDICT_W-1:0] {
    V_OK        = 3'd0,
    V_GROSS     = 3'd1,
    V_GRACE     = 3'd2,
    V_REFUSED   = 3'd3,
    V_LOG       = 3'd4,
    V_UNCHECKED = 3'd5
  } verdict_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SQ, ST_JUMP, ST_SEED, ST_CAP, ST_REFILL,
    ST_ADD, ST_SQRT, ST_DECIDE, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_SQ, OP_JUMP, OP_SEED, OP_CAP,
    OP_REFILL, OP_ADD, OP_SQRT, OP_DECIDE, OP_PUSH
  } op_t;

  typedef struct packed {
    op_t op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic gross;
    logic checked;
    logic sqrt_last;
    logic clear_last;
    logic out_free;
  } ctrl_sts_t;

  typedef struct packed {
    logic              seeded;
    logic [POS_W-1:0]  px;
    logic [POS_W-1:0]  py;
    logic [POS_W-1:0]  pz;
    logic [CELL_W-1:0] cid;
    logic [TIME_W-1:0] ltime;
    logic [BKT_W-1:0]  bxy;
    logic [BKT_W-1:0]  bup;
    logic [BKT_W-1:0]  bdn;
    logic              gv;
    logic [TIME_W-1:0] gend;
    logic              sv;
    logic [TIME_W-1:0] lsnap;
  } slot_t;

endpackage
`default_nettype wire

### rtl/mtbv_req_if.sv
// Move report channel.
`default_nettype none
interface mtbv_req_if import mtbv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] actor_slot;
  logic              is_player;
  logic [TIME_W-1:0] time_ms;
  logic [POS_W-1:0]  cur_x;
  logic [POS_W-1:0]  cur_y;
  logic [POS_W-1:0]  cur_z;
  logic [CELL_W-1:0] cur_cell;
  logic [POS_W-1:0]  new_x;
  logic [POS_W-1:0]  new_y;
  logic [POS_W-1:0]  new_z;
  logic [CELL_W-1:0] new_cell;

  modport source (output valid, actor_slot, is_player, time_ms, cur_x, cur_y, cur_z,
                  cur_cell, new_x, new_y, new_z, new_cell, input ready);
  modport sink   (input valid, actor_slot, is_player, time_ms, cur_x, cur_y, cur_z,
                  cur_cell, new_x, new_y, new_z, new_cell, output ready);
endinterface
`default_nettype wire

### rtl/mtbv_rsp_if.sv
// Verdict channel.
`default_nettype none
interface mtbv_rsp_if import mtbv_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 accepted;
  logic                 snap_back;
  logic [VERDICT_W-1:0] verdict;

  modport source (output valid, accepted, snap_back, verdict, input ready);
  modport sink   (input valid, accepted, snap_back, verdict, output ready);
endinterface
`default_nettype wire

### rtl/mtbv_cfg_if.sv
// Configuration write channel.
`default_nettype none
interface mtbv_cfg_if import mtbv_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface
`default_nettype wire

### rtl/mtbv_ctrl.sv
// Sequencer that steps one move report through the datapath.
`default_nettype none
module mtbv_ctrl import mtbv_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_ready,
  input  wire ctrl_sts_t sts,
  output ctrl_cmd_t      cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    req_ready  = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (sts.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.op     = OP_LOAD;
          state_next = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.op     = OP_SQ;
        state_next = ST_JUMP;
      end
      ST_JUMP: begin
        cmd.op = OP_JUMP;
        // Gross rejects and unchecked reports are settled here.
        if (sts.gross || !sts.checked) state_next = ST_DONE;
        else state_next = ST_SEED;
      end
      ST_SEED: begin
        cmd.op     = OP_SEED;
        state_next = ST_CAP;
      end
      ST_CAP: begin
        cmd.op     = OP_CAP;
        state_next = ST_REFILL;
      end
      ST_REFILL: begin
        cmd.op     = OP_REFILL;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.op     = OP_ADD;
        state_next = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.op = OP_SQRT;
        if (sts.sqrt_last) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.op     = OP_DECIDE;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.op     = OP_PUSH;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

endmodule
`default_nettype wire

### rtl/mtbv_dp.sv
// Datapath: configuration, slot memory, jump check, bucket lanes, square root.
`default_nettype none
module mtbv_dp import mtbv_pkg::*; #(
  parameter int ACTOR_SLOTS = ACTOR_SLOTS_DEF,
  parameter int MAX_JUMP    = MAX_JUMP_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire ctrl_cmd_t cmd,
  output ctrl_sts_t      sts,
  mtbv_req_if.sink       req,
  mtbv_rsp_if.source     rsp,
  mtbv_cfg_if.sink       cfg
);

  localparam int SW    = (ACTOR_SLOTS > 1) ? $clog2(ACTOR_SLOTS) : 1;
  localparam int AW    = POS_W + 1;
  localparam int SQW   = 2 * AW;
  localparam int SUMW  = SQW + 2;
  localparam longint unsigned LIM64 = longint'(MAX_JUMP) * longint'(MAX_JUMP);
  localparam logic [SUMW-1:0] LIM = SUMW'(LIM64);
  localparam int HW    = 2 * $clog2(MAX_JUMP) + 1;
  localparam int RW    = $clog2(MAX_JUMP * MILLI) + 1;
  localparam int VW    = 2 * RW;
  localparam int CW    = $clog2(RW + 1);
  localparam int SCW   = HW + SQ_SCALE_W;
  localparam int MW    = AW + 10;

  // Configuration registers; the port never stalls.
  logic              check_en, enforce;
  logic [RATE_W-1:0] h_rate, up_rate, dn_rate, burst, grace, snap_int;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_en <= 1'b0;
      enforce  <= 1'b0;
      h_rate   <= H_RATE_RST;
      up_rate  <= UP_RATE_RST;
      dn_rate  <= DN_RATE_RST;
      burst    <= BURST_RST;
      grace    <= GRACE_RST;
      snap_int <= SNAP_INT_RST;
    end else if (cfg.valid) begin
      case (cfg_idx_t'(cfg.addr))
        CFG_CHECK_EN: check_en <= cfg.data[0];
        CFG_ENFORCE:  enforce  <= cfg.data[0];
        CFG_H_RATE:   h_rate   <= cfg.data;
        CFG_UP_RATE:  up_rate  <= cfg.data;
        CFG_DN_RATE:  dn_rate  <= cfg.data;
        CFG_BURST:    burst    <= cfg.data;
        CFG_GRACE:    grace    <= cfg.data;
        CFG_SNAP_INT: snap_int <= cfg.data;
        default: ;
      endcase
    end
  end

  // Slot number folded onto the table depth.
  logic [SW-1:0] slot_map [2**SLOT_W];
  for (genvar g = 0; g < 2**SLOT_W; g++) begin : g_map
    assign slot_map[g] = SW'(g % ACTOR_SLOTS);
  end

  // Captured report.
  logic [SW-1:0]     slot_q;
  logic              player_q;
  logic [TIME_W-1:0] now_q;
  logic [POS_W-1:0]  cx_q, cy_q, cz_q, nx_q, ny_q, nz_q;
  logic [CELL_W-1:0] ccell_q, ncell_q;
  logic [AW-1:0]     ax, ay, az;
  logic              up_dir, dn_dir;

  logic signed [AW-1:0] dx, dy, dz;
  assign dx = $signed({req.new_x[POS_W-1], req.new_x}) - $signed({req.cur_x[POS_W-1], req.cur_x});
  assign dy = $signed({req.new_y[POS_W-1], req.new_y}) - $signed({req.cur_y[POS_W-1], req.cur_y});
  assign dz = $signed({req.new_z[POS_W-1], req.new_z}) - $signed({req.cur_z[POS_W-1], req.cur_z});

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      slot_q   <= slot_map[req.actor_slot];
      player_q <= req.is_player;
      now_q    <= req.time_ms;
      cx_q     <= req.cur_x;
      cy_q     <= req.cur_y;
      cz_q     <= req.cur_z;
      nx_q     <= req.new_x;
      ny_q     <= req.new_y;
      nz_q     <= req.new_z;
      ccell_q  <= req.cur_cell;
      ncell_q  <= req.new_cell;
      ax       <= dx[AW-1] ? AW'(-dx) : AW'(dx);
      ay       <= dy[AW-1] ? AW'(-dy) : AW'(dy);
      az       <= dz[AW-1] ? AW'(-dz) : AW'(dz);
      up_dir   <= !dz[AW-1] && (dz != '0);
      dn_dir   <= dz[AW-1];
    end
  end

  // Slot memory with a clearing pass after reset.
  slot_t         mem [ACTOR_SLOTS];
  slot_t         rd, wb;
  logic [SW-1:0] clr_cnt;
  logic          we;
  logic [SW-1:0] waddr;

  assign we    = (cmd.op == OP_CLEAR) || (cmd.op == OP_DECIDE);
  assign waddr = (cmd.op == OP_CLEAR) ? clr_cnt : slot_q;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= (cmd.op == OP_CLEAR) ? '0 : wb;
    if (cmd.op == OP_LOAD) rd <= mem[slot_map[req.actor_slot]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.op == OP_CLEAR) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Squares of the axis distances.
  logic [SQW-1:0]  sqx, sqy, sqz;
  logic [SUMW-1:0] sum3;
  logic [HW-1:0]   hsum;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SQ) begin
      sqx <= ax * ax;
      sqy <= ay * ay;
      sqz <= az * az;
    end
  end

  assign sum3 = SUMW'(sqx) + SUMW'(sqy) + SUMW'(sqz);

  // Slot state as seen after a possible reseed.
  logic              differ, reseed, srv_move;
  logic              reseed_q, gv_e;
  logic [TIME_W-1:0] gend_e, dt_raw;
  logic [RATE_W-1:0] dt_q, sec;
  logic [RW-1:0]     ucost, dcost;
  logic [MW-1:0]     zcost;

  assign differ   = (rd.px != cx_q) || (rd.py != cy_q) || (rd.pz != cz_q) ||
                    (rd.cid != ccell_q);
  assign reseed   = !rd.seeded || differ;
  assign srv_move = rd.seeded && differ;
  assign dt_raw   = now_q - rd.ltime;
  assign sec      = (burst < RATE_W'(MS_PER_S)) ? burst : RATE_W'(MS_PER_S);
  assign zcost    = MW'(az) * MW'(MILLI);

  always_ff @(posedge clk) begin
    if (cmd.op == OP_JUMP) begin
      hsum     <= HW'(SUMW'(sqx) + SUMW'(sqy));
      reseed_q <= reseed;
      gv_e     <= srv_move ? 1'b1 : rd.gv;
      gend_e   <= srv_move ? (now_q + TIME_W'(grace)) : rd.gend;
      if (reseed) dt_q <= '0;
      else if (dt_raw > TIME_W'(burst)) dt_q <= burst;
      else dt_q <= dt_raw[RATE_W-1:0];
      ucost    <= up_dir ? RW'(zcost) : '0;
      dcost    <= dn_dir ? RW'(zcost) : '0;
    end
  end

  // Three bucket lanes: horizontal, up, down.
  logic [RATE_W-1:0] lane_rate [3];
  logic [BKT_W-1:0]  lane_rd   [3];
  logic [RATE_W-1:0] lane_opnd;
  logic [BKT_W-1:0]  prod [3];
  logic [BKT_W-1:0]  cap  [3];
  logic [BKT_W-1:0]  bkt  [3];
  logic [BKT_W:0]    lane_sum [3];

  assign lane_rate[0] = h_rate;
  assign lane_rate[1] = up_rate;
  assign lane_rate[2] = dn_rate;
  assign lane_rd[0]   = rd.bxy;
  assign lane_rd[1]   = rd.bup;
  assign lane_rd[2]   = rd.bdn;

  always_comb begin
    case (cmd.op)
      OP_SEED: lane_opnd = sec;
      OP_CAP:  lane_opnd = burst;
      default: lane_opnd = dt_q;
    endcase
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    assign lane_sum[k] = {1'b0, bkt[k]} + {1'b0, prod[k]};
    always_ff @(posedge clk) begin
      if (cmd.op == OP_SEED || cmd.op == OP_CAP || cmd.op == OP_REFILL) begin
        prod[k] <= BKT_W'(lane_rate[k]) * BKT_W'(lane_opnd);
      end
      if (cmd.op == OP_CAP) bkt[k] <= reseed_q ? prod[k] : lane_rd[k];
      if (cmd.op == OP_REFILL) cap[k] <= prod[k];
      if (cmd.op == OP_ADD) begin
        bkt[k] <= (lane_sum[k] < {1'b0, cap[k]}) ? lane_sum[k][BKT_W-1:0] : cap[k];
      end
    end
  end

  // Rounded-up square root, one result bit per cycle.
  logic [SCW-1:0] scaled;
  logic [VW-1:0]  sq_in, sq_x;
  logic [RW+1:0]  rem, r2, trial;
  logic [RW-1:0]  root;
  logic [CW-1:0]  sq_cnt;

  assign scaled = SCW'(hsum) * SCW'(SQ_SCALE);
  assign r2     = {rem[RW-1:0], sq_x[VW-1 -: 2]};
  assign trial  = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SEED) sq_in <= VW'(scaled);
    if (cmd.op == OP_ADD) begin
      rem    <= '0;
      root   <= '0;
      sq_x   <= sq_in;
      sq_cnt <= CW'(RW - 1);
    end else if (cmd.op == OP_SQRT) begin
      sq_x   <= {sq_x[VW-3:0], 2'b00};
      sq_cnt <= sq_cnt - 1'b1;
      if (r2 >= trial) begin
        rem  <= r2 - trial;
        root <= {root[RW-2:0], 1'b1};
      end else begin
        rem  <= r2;
        root <= {root[RW-2:0], 1'b0};
      end
    end
  end

  // Verdict.
  logic [RW:0]       dxy;
  logic              ok, take, in_grace, snap_due;
  logic [TIME_W-1:0] gd, since_snap;
  logic [BKT_W-1:0]  spent [3];
  logic [BKT_W:0]    cost  [3];

  assign dxy        = {1'b0, root} + {{RW{1'b0}}, (rem != '0)};
  assign cost[0]    = (BKT_W+1)'(dxy);
  assign cost[1]    = (BKT_W+1)'(ucost);
  assign cost[2]    = (BKT_W+1)'(dcost);
  assign ok         = (cost[0] <= {1'b0, bkt[0]}) && (cost[1] <= {1'b0, bkt[1]}) &&
                      (cost[2] <= {1'b0, bkt[2]});
  assign take       = ok || !enforce;
  assign gd         = gend_e - now_q;
  assign in_grace   = gv_e && (gd != '0) && !gd[TIME_W-1];
  assign since_snap = now_q - rd.lsnap;
  assign snap_due   = !rd.sv || (since_snap >= TIME_W'(snap_int));

  for (genvar k = 0; k < 3; k++) begin : g_spend
    assign spent[k] = (cost[k] >= {1'b0, bkt[k]}) ? '0 : BKT_W'({1'b0, bkt[k]} - cost[k]);
  end

  always_comb begin
    wb        = rd;
    wb.seeded = 1'b1;
    wb.ltime  = now_q;
    wb.gv     = gv_e && in_grace;
    wb.gend   = gend_e;
    if (take) begin
      wb.px   = nx_q;
      wb.py   = ny_q;
      wb.pz   = nz_q;
      wb.cid  = ncell_q;
      wb.bxy  = spent[0];
      wb.bup  = spent[1];
      wb.bdn  = spent[2];
    end else begin
      // A refused report leaves the slot at the server position.
      wb.px   = cx_q;
      wb.py   = cy_q;
      wb.pz   = cz_q;
      wb.cid  = ccell_q;
      wb.bxy  = bkt[0];
      wb.bup  = bkt[1];
      wb.bdn  = bkt[2];
      if (!in_grace && snap_due) begin
        wb.sv    = 1'b1;
        wb.lsnap = now_q;
      end
    end
  end

  // Result register and output register.
  logic     res_acc, res_snap;
  verdict_t res_verdict;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_JUMP) begin
      if (sts.gross) begin
        res_acc     <= 1'b0;
        res_snap    <= player_q;
        res_verdict <= V_GROSS;
      end else begin
        res_acc     <= 1'b1;
        res_snap    <= 1'b0;
        res_verdict <= V_UNCHECKED;
      end
    end else if (cmd.op == OP_DECIDE) begin
      if (take) begin
        res_acc     <= 1'b1;
        res_snap    <= 1'b0;
        res_verdict <= ok ? V_OK : V_LOG;
      end else if (in_grace) begin
        res_acc     <= 1'b0;
        res_snap    <= 1'b0;
        res_verdict <= V_GRACE;
      end else begin
        res_acc     <= 1'b0;
        res_snap    <= snap_due;
        res_verdict <= V_REFUSED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.op == OP_PUSH) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_PUSH) begin
      rsp.accepted  <= res_acc;
      rsp.snap_back <= res_snap;
      rsp.verdict   <= res_verdict;
    end
  end

  assign sts.gross      = (ccell_q != ncell_q) || (sum3 >= LIM);
  assign sts.checked    = player_q && check_en;
  assign sts.sqrt_last  = (sq_cnt == '0);
  assign sts.clear_last = (clr_cnt == SW'(ACTOR_SLOTS - 1));
  assign sts.out_free   = !rsp.valid || rsp.ready;

endmodule
`default_nettype wire

### rtl/movement_token_bucket_validator.sv
// Movement validator with per-slot token buckets: top level.
//
// Channels: req carries one move report per transfer, rsp one verdict per
// report, cfg writes one configuration register per transfer (never stalls).
// Reports are handled one at a time. A gross reject or an unchecked report
// is settled at the jump check, right after the slot read and the squares, and
// its verdict goes to the output register. A checked report goes on through
// the seed, cap, refill and add steps of the bucket lanes, the bit-serial
// square root of the horizontal cost (RW = clog2(MAX_JUMP * 1000) + 1 result
// bits) and the decision before its verdict is pushed; the square root is the
// longest of these steps.
// The verdict sits in an output register; req takes the next report while it
// waits, and a report that finishes while rsp still stalls is held back until
// the register frees, so req stays low meanwhile.
// After reset the slot table is swept clear, one slot per cycle, over all
// ACTOR_SLOTS slots; req is low during that sweep, cfg writes are taken.
// Configuration writes take effect at once, also on a report in flight.
`default_nettype none
module movement_token_bucket_validator import mtbv_pkg::*; #(
  parameter int ACTOR_SLOTS = ACTOR_SLOTS_DEF,
  parameter int MAX_JUMP    = MAX_JUMP_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  mtbv_req_if.sink   req,
  mtbv_rsp_if.source rsp,
  mtbv_cfg_if.sink   cfg
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic      req_ready;

  assign req.ready = req_ready;

  mtbv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mtbv_dp #(
    .ACTOR_SLOTS (ACTOR_SLOTS),
    .MAX_JUMP    (MAX_JUMP)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .sts (sts),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

endmodule
`default_nettype wire

### rtl/mtbv_chk.sv
// Port-level assertions for the movement validator, bound to the top level.
`default_nettype none
module mtbv_chk import mtbv_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 req_ready,
  input wire logic                 rsp_valid,
  input wire logic                 rsp_ready,
  input wire logic                 rsp_accepted,
  input wire logic                 rsp_snap_back,
  input wire logic [VERDICT_W-1:0] rsp_verdict
);

  // A stalled verdict transfer keeps its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_verdict) &&
    $stable(rsp_accepted) && $stable(rsp_snap_back))
    else $error("verdict changed while stalled");

  // Accepted moves carry exactly the accepting verdicts.
  a_acc_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_accepted == (rsp_verdict == V_OK || rsp_verdict == V_LOG ||
                                   rsp_verdict == V_UNCHECKED))
    else $error("accepted flag disagrees with verdict");

  // A snap-back only goes with a gross reject or a refusal.
  a_snap_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_snap_back |-> !rsp_accepted &&
    (rsp_verdict == V_GROSS || rsp_verdict == V_REFUSED))
    else $error("snap-back on a non-refusing verdict");

  // The slot table sweep follows reset, so no report is taken and no verdict shows.
  a_after_rst: assert property (@(posedge clk)
    $past(rst) |-> !req_ready && !rsp_valid)
    else $error("activity right after reset");

endmodule

bind movement_token_bucket_validator mtbv_chk u_chk (
  .clk           (clk),
  .rst           (rst),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_accepted  (rsp.accepted),
  .rsp_snap_back (rsp.snap_back),
  .rsp_verdict   (rsp.verdict)
);
`default_nettype wire

### verif/movement_token_bucket_validator_tb.sv
// Self-checking testbench for the movement token bucket validator.
`timescale 1ns / 100ps
`default_nettype none
module movement_token_bucket_validator_tb;
  import mtbv_pkg::*;

  localparam int SLOTS = 64;
  localparam longint JUMP_SQ = 64'd4096 * 64'd4096;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [SLOT_W-1:0] slot;
    logic              player;
    logic [TIME_W-1:0] tms;
    logic [POS_W-1:0]  cx, cy, cz;
    logic [CELL_W-1:0] ccell;
    logic [POS_W-1:0]  nx, ny, nz;
    logic [CELL_W-1:0] ncell;
  } move_t;

  typedef struct {
    logic     acc;
    logic     snap;
    verdict_t verd;
  } ruling_t;

  // One directed row: the report plus an optional hand-written verdict.
  typedef struct {
    move_t    mv;
    logic     known;
    ruling_t  want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mtbv_req_if req();
  mtbv_rsp_if rsp();
  mtbv_cfg_if cfg();

  movement_token_bucket_validator dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg));

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor copy of configuration and slot table.
  logic        p_check, p_enforce;
  logic [15:0] p_hrate, p_uprate, p_dnrate, p_burst, p_grace, p_snapint;
  slot_t       tbl [SLOTS];

  ruling_t verdicts_due[$];
  int      mismatches = 0;
  int      idle_pct = 0;
  int      stall_pct = 0;
  int      quiet_cycles = 0;
  bit      timed_out = 1'b0;

  function automatic longint sext(logic [POS_W-1:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint unsigned ceil_root(longint unsigned v);
    longint unsigned lo = 0, hi = 64'd4294967296, mid;
    // Smallest r with r*r >= v.
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (mid * mid >= v) hi = mid;
      else lo = mid + 1;
    end
    return lo;
  endfunction

  function automatic logic [31:0] topped_up(logic [31:0] b, logic [15:0] rate, logic [31:0] dt);
    longint unsigned cap, v;
    cap = longint'(rate) * longint'(p_burst);
    v = longint'(b) + longint'(rate) * longint'(dt);
    return (v < cap) ? v[31:0] : cap[31:0];
  endfunction

  function automatic logic [31:0] drained(logic [31:0] b, longint unsigned c);
    return (c >= longint'(b)) ? 32'd0 : 32'(longint'(b) - c);
  endfunction

  function automatic void reseed(int s, move_t m);
    longint unsigned sec;
    sec = (p_burst < 16'd1000) ? p_burst : 1000;
    tbl[s].seeded = 1'b1;
    tbl[s].px = m.cx; tbl[s].py = m.cy; tbl[s].pz = m.cz;
    tbl[s].cid = m.ccell;
    tbl[s].ltime = m.tms;
    tbl[s].bxy = 32'(longint'(p_hrate) * sec);
    tbl[s].bup = 32'(longint'(p_uprate) * sec);
    tbl[s].bdn = 32'(longint'(p_dnrate) * sec);
  endfunction

  function automatic ruling_t judge_move(move_t m);
    ruling_t r;
    int s;
    longint unsigned ax, ay, az, cost_xy, cost_up, cost_dn;
    logic [31:0] dt, gd;
    logic in_grace, fits;
    s = m.slot;
    ax = (sext(m.nx) > sext(m.cx)) ? sext(m.nx) - sext(m.cx) : sext(m.cx) - sext(m.nx);
    ay = (sext(m.ny) > sext(m.cy)) ? sext(m.ny) - sext(m.cy) : sext(m.cy) - sext(m.ny);
    az = (sext(m.nz) > sext(m.cz)) ? sext(m.nz) - sext(m.cz) : sext(m.cz) - sext(m.nz);
    if (m.ccell != m.ncell || ax * ax + ay * ay + az * az >= JUMP_SQ) begin
      r.acc = 1'b0; r.snap = m.player; r.verd = V_GROSS;
      return r;
    end
    if (!m.player || !p_check) begin
      r.acc = 1'b1; r.snap = 1'b0; r.verd = V_UNCHECKED;
      return r;
    end
    if (!tbl[s].seeded) reseed(s, m);
    else if (tbl[s].px != m.cx || tbl[s].py != m.cy || tbl[s].pz != m.cz ||
             tbl[s].cid != m.ccell) begin
      reseed(s, m);
      tbl[s].gend = m.tms + p_grace;
      tbl[s].gv = 1'b1;
    end
    dt = m.tms - tbl[s].ltime;
    if (dt > p_burst) dt = p_burst;
    tbl[s].ltime = m.tms;
    tbl[s].bxy = topped_up(tbl[s].bxy, p_hrate, dt);
    tbl[s].bup = topped_up(tbl[s].bup, p_uprate, dt);
    tbl[s].bdn = topped_up(tbl[s].bdn, p_dnrate, dt);
    cost_xy = ceil_root((ax * ax + ay * ay) * 64'd1000000);
    cost_up = (sext(m.nz) > sext(m.cz)) ? az * 1000 : 0;
    cost_dn = (sext(m.nz) < sext(m.cz)) ? az * 1000 : 0;
    gd = tbl[s].gend - m.tms;
    in_grace = tbl[s].gv && gd != 0 && !gd[31];
    if (tbl[s].gv && !in_grace) tbl[s].gv = 1'b0;
    fits = cost_xy <= tbl[s].bxy && cost_up <= tbl[s].bup && cost_dn <= tbl[s].bdn;
    if (fits || !p_enforce) begin
      tbl[s].bxy = drained(tbl[s].bxy, cost_xy);
      tbl[s].bup = drained(tbl[s].bup, cost_up);
      tbl[s].bdn = drained(tbl[s].bdn, cost_dn);
      tbl[s].px = m.nx; tbl[s].py = m.ny; tbl[s].pz = m.nz;
      tbl[s].cid = m.ncell;
      r.acc = 1'b1; r.snap = 1'b0; r.verd = fits ? V_OK : V_LOG;
      return r;
    end
    r.acc = 1'b0; r.snap = 1'b0; r.verd = V_REFUSED;
    if (in_grace) r.verd = V_GRACE;
    else if (!tbl[s].sv || (m.tms - tbl[s].lsnap) >= p_snapint) begin
      tbl[s].sv = 1'b1;
      tbl[s].lsnap = m.tms;
      r.snap = 1'b1;
    end
    return r;
  endfunction

  // Receiver side: random stall and comparison against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (verdicts_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("verdict transfer with none expected");
        end else begin
          ruling_t w;
          w = verdicts_due.pop_front();
          if (rsp.accepted !== w.acc || rsp.snap_back !== w.snap || rsp.verdict !== w.verd) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected acc=%0b snap=%0b verdict=%0d, got acc=%0b snap=%0b verdict=%0d",
                       w.acc, w.snap, w.verd, rsp.accepted, rsp.snap_back, rsp.verdict);
          end
        end
      end
      rsp.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog on cycles with no transfer on any channel.
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    cfg.valid <= 1'b1;
    cfg.addr <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    case (idx)
      CFG_CHECK_EN: p_check = val[0];
      CFG_ENFORCE:  p_enforce = val[0];
      CFG_H_RATE:   p_hrate = val;
      CFG_UP_RATE:  p_uprate = val;
      CFG_DN_RATE:  p_dnrate = val;
      CFG_BURST:    p_burst = val;
      CFG_GRACE:    p_grace = val;
      default:      p_snapint = val;
    endcase
    @(posedge clk);
  endtask

  task automatic send_move(move_t m);
    while ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.actor_slot <= m.slot;   req.is_player <= m.player; req.time_ms <= m.tms;
    req.cur_x <= m.cx;          req.cur_y <= m.cy;         req.cur_z <= m.cz;
    req.cur_cell <= m.ccell;
    req.new_x <= m.nx;          req.new_y <= m.ny;         req.new_z <= m.nz;
    req.new_cell <= m.ncell;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    verdicts_due.push_back(judge_move(m));
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    // Let the last report leave the pipeline before anything else changes.
    repeat (60) @(posedge clk);
  endtask

  function automatic move_t any_move();
    move_t m;
    m.slot = SLOT_W'($urandom); m.player = 1'($urandom); m.tms = $urandom;
    m.cx = POS_W'($urandom); m.cy = POS_W'($urandom); m.cz = POS_W'($urandom);
    m.ccell = $urandom;
    m.nx = POS_W'($urandom); m.ny = POS_W'($urandom); m.nz = POS_W'($urandom);
    m.ncell = $urandom;
    return m;
  endfunction

  // Shadow of what the server last saw per slot, so random walks stay coherent.
  logic [POS_W-1:0]  walk_x [8], walk_y [8], walk_z [8];
  logic [CELL_W-1:0] walk_cell [8];
  logic [TIME_W-1:0] walk_t [8];

  function automatic move_t walk_move();
    move_t m;
    int k, step;
    k = $urandom_range(7);
    step = ($urandom_range(9) == 0) ? 3000 : 40;
    m.slot = SLOT_W'(k); m.player = ($urandom_range(9) != 0);
    walk_t[k] = walk_t[k] + $urandom_range(300);
    m.tms = walk_t[k];
    if ($urandom_range(14) == 0) begin
      walk_x[k] = POS_W'($urandom); walk_y[k] = POS_W'($urandom);
      walk_z[k] = POS_W'($urandom);
    end
    m.cx = walk_x[k]; m.cy = walk_y[k]; m.cz = walk_z[k];
    m.ccell = walk_cell[k];
    m.ncell = ($urandom_range(29) == 0) ? $urandom : walk_cell[k];
    m.nx = POS_W'(m.cx + $urandom_range(2 * step) - step);
    m.ny = POS_W'(m.cy + $urandom_range(2 * step) - step);
    m.nz = POS_W'(m.cz + $urandom_range(2 * step) - step);
    walk_x[k] = m.nx; walk_y[k] = m.ny; walk_z[k] = m.nz;
    return m;
  endfunction

  function automatic move_t mk(int slot, bit pl, int t, int x0, int z0, int x1, int z1, bit cellchg);
    move_t m;
    m.slot = SLOT_W'(slot); m.player = pl; m.tms = t;
    m.cx = POS_W'(x0); m.cy = '0; m.cz = POS_W'(z0); m.ccell = 32'd7;
    m.nx = POS_W'(x1); m.ny = '0; m.nz = POS_W'(z1); m.ncell = cellchg ? 32'd8 : 32'd7;
    return m;
  endfunction

  function automatic row_t rw(move_t m, bit known, bit a, bit sn, verdict_t v);
    row_t r;
    r.mv = m; r.known = known; r.want.acc = a; r.want.snap = sn; r.want.verd = v;
    return r;
  endfunction

  row_t rows[$];

  initial begin
    int phase;
    req.valid = 1'b0; cfg.valid = 1'b0;
    cfg.addr = '0; cfg.data = '0;
    req.actor_slot = '0; req.is_player = 1'b0; req.time_ms = '0;
    req.cur_x = '0; req.cur_y = '0; req.cur_z = '0; req.cur_cell = '0;
    req.new_x = '0; req.new_y = '0; req.new_z = '0; req.new_cell = '0;
    p_check = 1'b0; p_enforce = 1'b0;
    p_hrate = H_RATE_RST; p_uprate = UP_RATE_RST; p_dnrate = DN_RATE_RST;
    p_burst = BURST_RST; p_grace = GRACE_RST; p_snapint = SNAP_INT_RST;
    foreach (tbl[i]) tbl[i] = '0;
    for (int k = 0; k < 8; k++) begin
      walk_x[k] = POS_W'($urandom); walk_y[k] = POS_W'($urandom);
      walk_z[k] = POS_W'($urandom);
      walk_cell[k] = $urandom; walk_t[k] = $urandom;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows, checking off at reset.
    rows.push_back(rw(mk(0, 1, 0, 0, 0, 5, 5, 0), 1, 1, 0, V_UNCHECKED));
    rows.push_back(rw(mk(1, 1, 0, 0, 0, 5, 5, 1), 1, 0, 1, V_GROSS));
    rows.push_back(rw(mk(2, 0, 0, 0, 0, 5, 5, 1), 1, 0, 0, V_GROSS));
    rows.push_back(rw(mk(3, 1, 0, 0, 0, 4096, 0, 0), 1, 0, 1, V_GROSS));
    rows.push_back(rw(mk(3, 1, 0, 0, 0, 4095, 0, 0), 1, 1, 0, V_UNCHECKED));
    rows.push_back(rw(mk(4, 0, 0, -8388608, 8388607, -8388608, 8388607, 0), 1, 1, 0, V_UNCHECKED));
    rows.push_back(rw(mk(5, 1, 0, 8388607, 0, -8388608, 0, 0), 1, 0, 1, V_GROSS));
    foreach (rows[i]) begin
      send_move(rows[i].mv);
      if (rows[i].known) verdicts_due[$] = rows[i].want;
    end
    rows.delete();
    drain();

    write_reg(CFG_CHECK_EN, 16'd1);
    write_reg(CFG_ENFORCE, 16'd1);
    // Seed, spend, overrun, snap spacing, teleport grace, time wrap, top slot.
    rows.push_back(rw(mk(63, 1, 32'hFFFFFF00, 0, 0, 500, 0, 0), 0, 0, 0, V_OK));
    rows.push_back(rw(mk(63, 1, 32'hFFFFFF10, 500, 0, 1500, 0, 0), 0, 0, 0, V_OK));
    rows.push_back(rw(mk(63, 1, 32'hFFFFFF20, 500, 0, 500, 3000, 0), 0, 0, 0, V_OK));
    rows.push_back(rw(mk(63, 1, 32'hFFFFFF30, 500, 0, 500, -3000, 0), 0, 0, 0, V_OK));
    rows.push_back(rw(mk(63, 1, 32'h00000100, 500, 0, 500, 900, 0), 0, 0, 0, V_OK));
    rows.push_back(rw(mk(63, 1, 32'h00000101, 9000, 0, 12000, 0, 0), 0, 0, 0, V_OK));
    rows.push_back(rw(mk(63, 1, 32'h00000102, 12000, 0, 9000, 0, 0), 0, 0, 0, V_OK));
    rows.push_back(rw(mk(63, 1, 32'h00000700, 12000, 0, 15500, 0, 0), 0, 0, 0, V_OK));
    rows.push_back(rw(mk(63, 1, 32'h00000701, 15500, 0, 19000, 0, 0), 0, 0, 0, V_OK));
    rows.push_back(rw(mk(63, 1, 32'h00000702, 15500, 0, 19000, 0, 0), 0, 0, 0, V_OK));
    foreach (rows[i]) send_move(rows[i].mv);
    rows.delete();
    drain();

    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 65; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 65; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      write_reg(CFG_CHECK_EN, 16'(phase != 3));
      write_reg(CFG_ENFORCE, 16'(phase[0]));
      case (phase)
        2: begin
          write_reg(CFG_H_RATE, 16'd0); write_reg(CFG_UP_RATE, 16'd65535);
          write_reg(CFG_DN_RATE, 16'd0); write_reg(CFG_BURST, 16'd0);
          write_reg(CFG_GRACE, 16'd0); write_reg(CFG_SNAP_INT, 16'd65535);
        end
        5: begin
          write_reg(CFG_H_RATE, 16'd65535); write_reg(CFG_UP_RATE, 16'd0);
          write_reg(CFG_DN_RATE, 16'd65535); write_reg(CFG_BURST, 16'd65535);
          write_reg(CFG_GRACE, 16'd65535); write_reg(CFG_SNAP_INT, 16'd0);
        end
        default: begin
          write_reg(CFG_H_RATE, 16'($urandom_range(3000)));
          write_reg(CFG_UP_RATE, 16'($urandom_range(3000)));
          write_reg(CFG_DN_RATE, 16'($urandom_range(3000)));
          write_reg(CFG_BURST, 16'($urandom_range(3000)));
          write_reg(CFG_GRACE, 16'($urandom_range(2000)));
          write_reg(CFG_SNAP_INT, 16'($urandom_range(800)));
        end
      endcase
      for (int n = 0; n < 88; n++) begin
        send_move(($urandom_range(4) == 0) ? any_move() : walk_move());
        // Hold off now and then until every verdict is back.
        if (n == 40) drain();
      end
      drain();
    end

    if (mismatches == 0 && !timed_out)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
rtl/mtbv_pkg.sv
rtl/mtbv_req_if.sv
rtl/mtbv_rsp_if.sv
rtl/mtbv_cfg_if.sv
rtl/mtbv_ctrl.sv
rtl/mtbv_dp.sv
rtl/movement_token_bucket_validator.sv
rtl/mtbv_chk.sv
verif/movement_token_bucket_validator_tb.sv
